[sv/c2s_pkg.sv]
package c2s_pkg;

   // default number of cordic iterations
   localparam int CORDIC_STAGES_DEF = 24;
   // width of the cordic x/y datapath (coordinate scaled by 2^24 plus gain headroom)
   localparam int CW = 60;
   // number of result bits of the square root
   localparam int SQ_BITS = 32;
   // angle of half a turn in units of a turn / 2^32
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // partial square root travelling along the root chain
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // vector and accumulated angle travelling along the cordic chain
   typedef struct packed {
      logic                 hold;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [31:0]          ang;
   } cordic_type;

   // atan(2^-i) in units of a full turn / 2^32
   function automatic logic [31:0] atan_value(input int idx);
      logic [31:0] val;
      case (idx)
         0: val = 32'h2000_0000;
         1: val = 32'h12E4_051E;
         2: val = 32'h09FB_385B;
         3: val = 32'h0511_11D4;
         4: val = 32'h028B_0D43;
         5: val = 32'h0145_D7E1;
         6: val = 32'h00A2_F61E;
         7: val = 32'h0051_7C55;
         8: val = 32'h0028_BE53;
         9: val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2FA;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0029;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0003;
         29: val = 32'h0000_0001;
         30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

[sv/c2s_isqrt_cell.sv]
module c2s_isqrt_cell
   import c2s_pkg::*;
#(
   parameter int BIT = 31
) (
   input  logic     clock,
   input  logic     enable,
   input  sqrt_type src,
   output sqrt_type dst
);

   sqrt_type    dst_ff;
   sqrt_type    dst_in;
   logic [65:0] delta;

   // try setting this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
   always_comb begin
      delta = (66'(src.root) << (BIT + 1)) | (66'd1 << (2 * BIT));
      dst_in = src;
      if (delta <= {2'b00, src.rem}) begin
         dst_in.rem  = src.rem - delta[63:0];
         dst_in.root = src.root | (32'd1 << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

[sv/c2s_cordic_cell.sv]
module c2s_cordic_cell
   import c2s_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       enable,
   input  cordic_type src,
   output cordic_type dst
);

   localparam logic [31:0] ATAN = atan_value(SHIFT);

   cordic_type           dst_ff;
   cordic_type           dst_in;
   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;

   // one vectoring micro-rotation towards the x axis
   always_comb begin
      xs = src.x >>> SHIFT;
      ys = src.y >>> SHIFT;
      dst_in = src;
      if (!src.hold) begin
         if (!src.y[CW-1]) begin
            dst_in.x   = src.x + ys;
            dst_in.y   = src.y - xs;
            dst_in.ang = src.ang + ATAN;
         end else begin
            dst_in.x   = src.x - ys;
            dst_in.y   = src.y + xs;
            dst_in.ang = src.ang - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

[sv/cartesian_to_spherical_unit.sv]
// channel   | dir | handshake              | payload
// req       | in  | req_tvalid/req_tready  | x_coord, y_coord, z_coord
// rsp       | out | rsp_tvalid/rsp_tready  | radius, azimuth, polar
// csr       | in  | csr_we                 | quantize_tenths
//
// one point per clock while the output register is not stalled; each point runs through
// the rounding, square and sum stages, the 32 cell square root chain and the cordic chain of CORDIC_STAGES cells
// synchronous reset clears the valid line and the rounding bit
// the whole pipeline holds while a result waits in the output register
module cartesian_to_spherical_unit
   import c2s_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // x_coord[31:0], y_coord[63:32], z_coord[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // radius[31:0], azimuth[55:32], polar[79:56]
   input  logic        csr_we,
   input  logic        csr_wdata
);

   localparam int VL = 5 + SQ_BITS + 1 + CORDIC_STAGES;
   localparam logic [23:0] QMUL = 24'd13421773;   // ceil(2^27 / 10)

   logic          en;
   logic          quant_ff;
   logic [VL-1:0] vld_ff;
   logic          rsp_tvalid_ff;
   logic [79:0]   rsp_tdata_ff;
   logic [79:0]   rsp_tdata_in;

   // rounding stages
   logic [2:0][31:0] raw;
   logic [2:0][31:0] raw1_ff, raw2_ff;
   logic [2:0][18:0] n1_ff;
   logic [2:0]       neg1_ff, neg2_ff;
   logic [2:0][31:0] t2_ff;
   logic [2:0][17:0] quo2_ff;
   logic [2:0][31:0] crd3_ff;
   logic [2:0][18:0] n1_in;
   logic [2:0][31:0] t2_in;
   logic [2:0][17:0] quo2_in;
   logic [2:0][31:0] crd3_in;

   // square and sum stages
   logic [2:0][63:0] sq_ff;
   logic [2:0][31:0] crd4_ff;
   logic [63:0]      sxy_ff, sall_ff;
   logic [2:0][31:0] crd5_ff;

   // root chains
   sqrt_type         rxy_c  [SQ_BITS+1];
   sqrt_type         rall_c [SQ_BITS+1];
   logic [2:0][31:0] crd_sh_ff [SQ_BITS];

   // cordic chains
   cordic_type       az_c [CORDIC_STAGES+1];
   cordic_type       po_c [CORDIC_STAGES+1];
   cordic_type       az_pre_ff, po_pre_ff;
   logic [31:0]      rad_pre_ff;
   logic [31:0]      rad_sh_ff [CORDIC_STAGES];
   logic [31:0]      az_round, po_round;
   logic [23:0]      po_clamp;

   function automatic cordic_type cordic_init(input logic signed [33:0] px,
                                              input logic signed [33:0] py);
      cordic_type           c;
      logic signed [CW-1:0] xe;
      logic signed [CW-1:0] ye;
      xe = CW'(px) <<< 24;
      ye = CW'(py) <<< 24;
      c.hold = (py == 34'sd0);
      c.x    = xe;
      c.y    = ye;
      c.ang  = 32'd0;
      if (c.hold) begin
         c.ang = px[33] ? HALF_TURN : 32'd0;
      end else if (px[33]) begin
         c.x   = -xe;
         c.y   = -ye;
         c.ang = HALF_TURN;
      end
      return c;
   endfunction

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // rounding bit
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff <= 1'b0;
      end else if (csr_we) begin
         quant_ff <= csr_wdata;
      end
   end

   // valid line and output flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[VL-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[VL-1];
      end
   end

   // rounding to the nearest tenth, per coordinate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [31:0] mag;
         logic [34:0] scaled;
         logic [20:0] a;
         logic [44:0] p;
         logic [32:0] qm;
         raw[k]     = req_tdata[32*k +: 32];
         mag        = raw[k][31] ? (32'd0 - raw[k]) : raw[k];
         scaled     = (35'(mag) << 3) + (35'(mag) << 1) + 35'd32768;
         n1_in[k]   = scaled[34:16];
         t2_in[k]   = 32'(n1_ff[k]) * 32'd6553;
         a          = 21'(n1_ff[k]) * 21'd6 + 21'd5;
         p          = 45'(a) * 45'(QMUL);
         quo2_in[k] = p[44:27];
         qm         = {1'b0, t2_ff[k]} + 33'(quo2_ff[k]);
         if (!quant_ff) begin
            crd3_in[k] = raw2_ff[k];
         end else if (neg2_ff[k]) begin
            crd3_in[k] = 32'd0 - qm[31:0];
         end else if (qm > 33'h0_7FFF_FFFF) begin
            crd3_in[k] = 32'h7FFF_FFFF;
         end else begin
            crd3_in[k] = qm[31:0];
         end
      end
   end

   // rounding, squares and sums
   always_ff @(posedge clock) begin
      if (en) begin
         raw1_ff <= raw;
         n1_ff   <= n1_in;
         for (int k = 0; k < 3; k++) begin
            neg1_ff[k] <= raw[k][31];
         end
         raw2_ff <= raw1_ff;
         neg2_ff <= neg1_ff;
         t2_ff   <= t2_in;
         quo2_ff <= quo2_in;
         crd3_ff <= crd3_in;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= 64'($signed(crd3_ff[k])) * 64'($signed(crd3_ff[k]));
         end
         crd4_ff <= crd3_ff;
         sxy_ff  <= sq_ff[0] + sq_ff[1];
         sall_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         crd5_ff <= crd4_ff;
      end
   end

   assign rxy_c[0]  = '{rem: sxy_ff,  root: 32'd0};
   assign rall_c[0] = '{rem: sall_ff, root: 32'd0};

   // square root chains, one result bit a cell
   for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
      c2s_isqrt_cell #(.BIT(SQ_BITS - 1 - j)) u_rxy (
         .clock  (clock),
         .enable (en),
         .src    (rxy_c[j]),
         .dst    (rxy_c[j+1])
      );
      c2s_isqrt_cell #(.BIT(SQ_BITS - 1 - j)) u_rall (
         .clock  (clock),
         .enable (en),
         .src    (rall_c[j]),
         .dst    (rall_c[j+1])
      );
   end

   // coordinates alongside the root chains
   always_ff @(posedge clock) begin
      if (en) begin
         crd_sh_ff[0] <= crd5_ff;
         for (int j = 1; j < SQ_BITS; j++) begin
            crd_sh_ff[j] <= crd_sh_ff[j-1];
         end
      end
   end

   // cordic set-up: axis cases and left half-plane fold
   always_ff @(posedge clock) begin
      if (en) begin
         az_pre_ff  <= cordic_init(34'($signed(crd_sh_ff[SQ_BITS-1][0])),
                                   34'($signed(crd_sh_ff[SQ_BITS-1][1])));
         po_pre_ff  <= cordic_init(34'($signed(crd_sh_ff[SQ_BITS-1][2])),
                                   $signed({2'b00, rxy_c[SQ_BITS].root}));
         rad_pre_ff <= rall_c[SQ_BITS].root;
      end
   end

   assign az_c[0] = az_pre_ff;
   assign po_c[0] = po_pre_ff;

   // cordic chains, one micro-rotation a cell
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      c2s_cordic_cell #(.SHIFT(i)) u_az (
         .clock  (clock),
         .enable (en),
         .src    (az_c[i]),
         .dst    (az_c[i+1])
      );
      c2s_cordic_cell #(.SHIFT(i)) u_po (
         .clock  (clock),
         .enable (en),
         .src    (po_c[i]),
         .dst    (po_c[i+1])
      );
   end

   // radius alongside the cordic chains
   always_ff @(posedge clock) begin
      if (en) begin
         rad_sh_ff[0] <= rad_pre_ff;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            rad_sh_ff[i] <= rad_sh_ff[i-1];
         end
      end
   end

   // round angles to 24 bits and clamp the polar overshoot
   always_comb begin
      az_round = az_c[CORDIC_STAGES].ang + 32'd128;
      po_round = po_c[CORDIC_STAGES].ang + 32'd128;
      po_clamp = po_round[31:8];
      if (po_clamp > 24'h80_0000) begin
         po_clamp = (po_clamp >= 24'hC0_0000) ? 24'h00_0000 : 24'h80_0000;
      end
      rsp_tdata_in = {po_clamp, az_round[31:8], rad_sh_ff[CORDIC_STAGES-1]};
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

endmodule

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import c2s_pkg::*;

   localparam int STAGES = 24;
   localparam int LATENCY = 39 + STAGES;
   localparam int RANDOM_POINTS = 1230;
   localparam int STALL_LIMIT = 20000;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   typedef struct packed {
      logic [23:0] polar;
      logic [23:0] azimuth;
      logic [31:0] radius;
   } sphere_type;

   // directed row: point, and an expected result where it is obvious
   typedef struct {
      point_type  pt;
      logic       known;
      sphere_type res;
   } point_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   cartesian_to_spherical_unit #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic        tenths_mode = 1'b0;
   sphere_type  expected_spheres[$];
   int          mismatches = 0;
   int          points_sent = 0;
   int          spheres_seen = 0;
   int          idle_cycles = 0;
   logic        rsp_stall_on = 1'b1;

   // magnitude -> nearest tenth held as q16.16
   function automatic longint snap_tenth(longint v);
      longint unsigned m, n, q;
      m = (v < 0) ? -v : v;
      n = (m * 10 + 32768) >> 16;
      q = (n * 65536 + 5) / 10;
      if (v < 0) return -longint'(q);
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned rem, res, b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // vectoring cordic, angle in turns / 2^32
   function automatic logic [31:0] cordic_angle(longint px, longint py);
      logic [31:0] ang;
      longint vx, vy, nx, ny;
      ang = '0;
      if (py == 0) return (px >= 0) ? 32'h0 : HALF_TURN;
      vx = px <<< 24;
      vy = py <<< 24;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         ang = HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (vy >= 0) begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            ang += atan_value(i);
         end else begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            ang -= atan_value(i);
         end
         vx = nx;
         vy = ny;
      end
      return ang;
   endfunction

   function automatic logic [23:0] turn_24(logic [31:0] a);
      logic [31:0] s;
      s = a + 32'd128;
      return s[31:8];
   endfunction

   function automatic sphere_type to_sphere(point_type p);
      longint x, y, z;
      longint unsigned sxy, sall, rxy;
      sphere_type r;
      x = longint'($signed(p.x));
      y = longint'($signed(p.y));
      z = longint'($signed(p.z));
      if (tenths_mode) begin
         x = snap_tenth(x);
         y = snap_tenth(y);
         z = snap_tenth(z);
      end
      sxy = x * x + y * y;
      sall = sxy + z * z;
      r.radius = root_floor(sall);
      rxy = root_floor(sxy);
      r.azimuth = turn_24(cordic_angle(x, y));
      r.polar = turn_24(cordic_angle(z, longint'(rxy)));
      if (r.polar > 24'h80_0000) r.polar = (r.polar >= 24'hC0_0000) ? 24'h0 : 24'h80_0000;
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 2000) - 1000;
         1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         3: return 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                   + $urandom_range(0, 3) - 2;
         4: return (($urandom_range(0, 400) - 200) * 6554);
         default: return $urandom;
      endcase
   endfunction

   // result checking and stall pattern
   always @(posedge clock) begin
      sphere_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            spheres_seen++;
            if (expected_spheres.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected result r=%h az=%h po=%h",
                           got.radius, got.azimuth, got.polar);
            end else begin
               want = expected_spheres.pop_front();
               if (got.radius !== want.radius || got.azimuth !== want.azimuth ||
                   got.polar !== want.polar) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("result %0d: expected r=%h az=%h po=%h, got r=%h az=%h po=%h",
                              spheres_seen, want.radius, want.azimuth, want.polar,
                              got.radius, got.azimuth, got.polar);
               end
            end
         end
         if (rsp_stall_on) rsp_tready <= (gap_length() == 0);
         else rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles with no request or result accepted
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // request stays valid across back to back points, dropped only for a gap
   task automatic send_point(point_type p, logic known, sphere_type res);
      int gap;
      sphere_type want;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      want = to_sphere(p);
      if (known && want !== res)
         $display("note: typed-in expectation differs from predictor for %h", p);
      req_tvalid <= 1'b1;
      req_tdata <= p;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_spheres.insert(expected_spheres.size(), known ? res : want);
      points_sent++;
   endtask

   task automatic set_tenths(logic v);
      req_tvalid <= 1'b0;
      while (expected_spheres.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tenths_mode = v;
   endtask

   function automatic point_row_type row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                         logic known, sphere_type res);
      point_row_type r;
      r.pt = '{z: z, y: y, x: x};
      r.known = known;
      r.res = res;
      return r;
   endfunction

   point_row_type directed[$];

   task automatic add_row(point_row_type r);
      directed.insert(directed.size(), r);
   endtask

   initial begin
      point_type p;
      logic tenths_pick;
      // axes, zero, extremes, polar overshoot and rounding cases
      add_row(row(0, 0, 0, 1, '{polar: 0, azimuth: 0, radius: 0}));
      add_row(row(32'h0001_0000, 0, 0, 1,
                  '{polar: 24'h40_0000, azimuth: 0, radius: 32'h0001_0000}));
      add_row(row(32'hFFFF_0000, 0, 0, 1,
                  '{polar: 24'h40_0000, azimuth: 24'h80_0000,
                    radius: 32'h0001_0000}));
      add_row(row(0, 0, 32'h0001_0000, 1,
                  '{polar: 0, azimuth: 0, radius: 32'h0001_0000}));
      add_row(row(0, 0, 32'hFFFF_0000, 1,
                  '{polar: 24'h80_0000, azimuth: 0, radius: 32'h0001_0000}));
      add_row(row(0, 32'h0001_0000, 0, 0, '0));
      add_row(row(0, 32'hFFFF_0000, 0, 0, '0));
      add_row(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0));
      add_row(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0));
      add_row(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0));
      add_row(row(32'h8000_0000, 0, 0, 0, '0));
      add_row(row(1, 0, 32'hFFFF_FFFF, 0, '0));
      add_row(row(1, 1, 32'h7FFF_FFFF, 0, '0));
      add_row(row(1, 0, 32'h8000_0000, 0, '0));
      add_row(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, '0));
      add_row(row(32'h0000_8000, 32'hFFFF_8000, 32'h0000_1999, 0, '0));
      add_row(row(32'h0001_8000, 32'h0000_0CCD, 32'hFFFF_F333, 0, '0));
      add_row(row(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 0, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, plain then with rounding to tenths
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) set_tenths(1'b1);
         foreach (directed[i])
            send_point(directed[i].pt, directed[i].known && pass == 0, directed[i].res);
      end

      // random points in phases of alternating rounding mode, with stall pressure in all but one phase
      for (int phase = 0; phase < 6; phase++) begin
         tenths_pick = (phase % 2 == 0) ? 1'b0 : 1'b1;
         set_tenths(tenths_pick);
         rsp_stall_on = (phase != 2);
         for (int n = 0; n < RANDOM_POINTS / 6; n++) begin
            p.x = random_coord();
            p.y = random_coord();
            p.z = random_coord();
            send_point(p, 1'b0, '0);
         end
      end

      // drain
      req_tvalid <= 1'b0;
      rsp_stall_on = 1'b0;
      while (expected_spheres.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("sent %0d points and checked %0d results, rounding to tenths off and on,",
               points_sent, spheres_seen);
      $display("covering axes, extremes and random coordinates under random stalls");
      if (mismatches == 0 && expected_spheres.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/c2s_pkg.sv
sv/c2s_isqrt_cell.sv
sv/c2s_cordic_cell.sv
sv/cartesian_to_spherical_unit.sv
bench/tb.sv
